// ----- src/min_max_three_term_fuzzifier_top_assert.svh -----
// Assertion macros used by the fuzzifier back end.
`ifndef MIN_MAX_THREE_TERM_FUZZIFIER_TOP_ASSERT_SVH
`define MIN_MAX_THREE_TERM_FUZZIFIER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MMF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fuzzifier assertion failed");
`define MMF_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fuzzifier reset assertion failed");
`else
`define MMF_ASSERT(lbl, clk, rst_n, prop)
`define MMF_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- src/mmfuzz_pkg.sv -----
// Package with the action codes of the fuzzifier.
package mmfuzz_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_FUZZ  = 2'd2
  } action_t;

endpackage

// ----- src/mmfuzz_front.sv -----
// Front end: range tracking and snapshot of span and offset for fuzzify transactions.
module mmfuzz_front #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [2*SAMPLE_BITS+1:0]      q_data
);

  localparam int S = SAMPLE_BITS;
  localparam logic signed [S-1:0] MOST_POS = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] MOST_NEG = {1'b1, {(S-1){1'b0}}};

  logic signed [S-1:0] range_min_r, range_min_nxt;
  logic signed [S-1:0] range_max_r, range_max_nxt;
  logic                accept;
  logic [S-1:0]        span;
  logic signed [S:0]   offset;
  logic                span_empty;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  assign span       = range_max_r - range_min_r;
  assign offset     = {in_sample_value[S-1], in_sample_value} - {range_min_r[S-1], range_min_r};
  assign span_empty = (range_max_r <= range_min_r);

  assign q_data = {span_empty, span, offset};

  always_comb begin
    range_min_nxt = range_min_r;
    range_max_nxt = range_max_r;
    q_push        = 1'b0;
    if (accept) begin
      case (mmfuzz_pkg::action_t'(in_action))
        mmfuzz_pkg::ACT_CLEAR: begin
          range_min_nxt = MOST_POS;
          range_max_nxt = MOST_NEG;
        end
        mmfuzz_pkg::ACT_ACCUM: begin
          if (in_sample_value < range_min_r) range_min_nxt = in_sample_value;
          if (in_sample_value > range_max_r) range_max_nxt = in_sample_value;
        end
        mmfuzz_pkg::ACT_FUZZ: begin
          q_push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= MOST_POS;
      range_max_r <= MOST_NEG;
    end else begin
      range_min_r <= range_min_nxt;
      range_max_r <= range_max_nxt;
    end
  end

endmodule

// ----- src/mmfuzz_queue.sv -----
// Two-entry queue between the front end and the divider back end.
module mmfuzz_queue #(
  parameter int WIDTH = 66
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= wdata;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/mmfuzz_back.sv -----
// Back end: region classification, radix-2 divider and result register.
`include "min_max_three_term_fuzzifier_top_assert.svh"
module mmfuzz_back #(
  parameter int SAMPLE_BITS = 32,
  parameter int GRADE_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [2*SAMPLE_BITS+1:0] q_data,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [GRADE_BITS-1:0]    out_grade_low,
  output logic [GRADE_BITS-1:0]    out_grade_mid,
  output logic [GRADE_BITS-1:0]    out_grade_high,
  output logic                     out_span_empty
);

  localparam int S     = SAMPLE_BITS;
  localparam int G     = GRADE_BITS;
  localparam int CNT_W = $clog2(G);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(G - 1);
  localparam logic [G-1:0]     ONE  = {1'b1, {(G-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_DIV, S_PUT} state_t;
  typedef enum logic [2:0] {R_EMPTY, R_BELOW, R_RISE, R_FALL, R_ABOVE} region_t;

  state_t            state_r, state_nxt;
  region_t           region_r, region_nxt;
  logic              spanz_r, spanz_nxt;
  logic signed [S:0] offs_r, offs_nxt;
  logic [S-1:0]      div_r, div_nxt;
  logic [S:0]        rem_r, rem_nxt;
  logic [G-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [G-1:0]      out_lo_r, out_lo_nxt;
  logic [G-1:0]      out_md_r, out_md_nxt;
  logic [G-1:0]      out_hi_r, out_hi_nxt;
  logic              out_se_r, out_se_nxt;

  logic signed [S+1:0] offs2;
  logic signed [S+1:0] offsx;
  logic signed [S+1:0] divx;
  logic [S:0]          fall_y;
  logic [S:0]          shifted;
  logic                ge;
  logic [G-1:0]        compl;
  logic                out_free;

  assign offs2    = {offs_r, 1'b0};
  assign offsx    = {offs_r[S], offs_r};
  assign divx     = $signed({2'b00, div_r});
  assign fall_y   = offs2[S:0] - {1'b0, div_r};
  assign shifted  = (cnt_r == '0) ? rem_r : {rem_r[S-1:0], 1'b0};
  assign ge       = (shifted >= {1'b0, div_r});
  assign compl    = ONE - quo_r - G'(rem_r != '0);
  assign out_free = !out_valid_r || out_pop;

  assign q_pop          = (state_r == S_IDLE) && !q_empty;
  assign out_empty      = !out_valid_r;
  assign out_grade_low  = out_lo_r;
  assign out_grade_mid  = out_md_r;
  assign out_grade_high = out_hi_r;
  assign out_span_empty = out_se_r;

  always_comb begin
    state_nxt     = state_r;
    region_nxt    = region_r;
    spanz_nxt     = spanz_r;
    offs_nxt      = offs_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_lo_nxt    = out_lo_r;
    out_md_nxt    = out_md_r;
    out_hi_nxt    = out_hi_r;
    out_se_nxt    = out_se_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          spanz_nxt = q_data[2*S+1];
          div_nxt   = q_data[2*S:S+1];
          offs_nxt  = $signed(q_data[S:0]);
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cnt_nxt = '0;
        quo_nxt = '0;
        rem_nxt = '0;
        if (spanz_r) begin
          region_nxt = R_EMPTY;
          state_nxt  = S_PUT;
        end else if (offs_r < 0) begin
          region_nxt = R_BELOW;
          state_nxt  = S_PUT;
        end else if (offs2 <= divx) begin
          region_nxt = R_RISE;
          rem_nxt    = offs2[S:0];
          state_nxt  = S_DIV;
        end else if (offsx <= divx) begin
          region_nxt = R_FALL;
          rem_nxt    = fall_y;
          state_nxt  = S_DIV;
        end else begin
          region_nxt = R_ABOVE;
          state_nxt  = S_PUT;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? shifted - {1'b0, div_r} : shifted;
        quo_nxt = {quo_r[G-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST) state_nxt = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_lo_nxt    = '0;
          out_md_nxt    = '0;
          out_hi_nxt    = '0;
          out_se_nxt    = 1'b0;
          case (region_r)
            R_EMPTY: out_se_nxt = 1'b1;
            R_BELOW: out_lo_nxt = ONE;
            R_RISE: begin
              out_md_nxt = quo_r;
              out_lo_nxt = compl;
            end
            R_FALL: begin
              out_hi_nxt = quo_r;
              out_md_nxt = compl;
            end
            R_ABOVE: out_hi_nxt = ONE;
            default: out_se_nxt = 1'b0;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    region_r <= region_nxt;
    spanz_r  <= spanz_nxt;
    offs_r   <= offs_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    out_lo_r <= out_lo_nxt;
    out_md_r <= out_md_nxt;
    out_hi_r <= out_hi_nxt;
    out_se_r <= out_se_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MMF_ASSERT_NORST(a_reset_idle, clk, !rst_n |=> !out_valid_r && state_r == S_IDLE)
  `MMF_ASSERT(a_div_runs, clk, rst_n, state_r == S_DIV && cnt_r != LAST |=> state_r == S_DIV)
  `MMF_ASSERT(a_rem_below_div, clk, rst_n, state_r == S_DIV && cnt_r != '0 |-> rem_r < {1'b0, div_r})
  `MMF_ASSERT(a_empty_zero, clk, rst_n, out_valid_r && out_se_r |-> out_lo_r == '0 && out_md_r == '0 && out_hi_r == '0)
  `MMF_ASSERT(a_grade_max, clk, rst_n, out_valid_r |-> out_lo_r <= ONE && out_md_r <= ONE && out_hi_r <= ONE)

endmodule

// ----- src/min_max_three_term_fuzzifier_top.sv -----
// A fuzzify transaction shows on the result ports after the radix-2 divider when its sample
// lies inside the range, and without a division otherwise; clear and accumulate give none.
// The back end takes a new fuzzify transaction only once its last result is put out, the
// divider doing one quotient bit per cycle; clear and accumulate only update the front end.
// Reset (synchronous, rst_n low): range empty, queue empty, divider idle, no result waiting.
module min_max_three_term_fuzzifier_top #(
  parameter int SAMPLE_BITS = 32,
  parameter int GRADE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [GRADE_BITS-1:0]         out_grade_low,
  output logic [GRADE_BITS-1:0]         out_grade_mid,
  output logic [GRADE_BITS-1:0]         out_grade_high,
  output logic                          out_span_empty
);

  localparam int QW = 2 * SAMPLE_BITS + 2;

  logic          q_push;
  logic          q_full;
  logic [QW-1:0] q_wdata;
  logic          q_pop;
  logic          q_empty;
  logic [QW-1:0] q_rdata;

  mmfuzz_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_sample_value(in_sample_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  mmfuzz_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .full (q_full),
    .wdata(q_wdata),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  mmfuzz_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .GRADE_BITS (GRADE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_rdata),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_grade_low (out_grade_low),
    .out_grade_mid (out_grade_mid),
    .out_grade_high(out_grade_high),
    .out_span_empty(out_span_empty)
  );

endmodule
